// File: hw/rtl/fixed_block_free_list_allocator_assert.svh
// Assertion macros for the free-list allocator.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked once reset is released.
`define FBFL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbfl assertion failed");

// Next-cycle implication, checked once reset is released.
`define FBFL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbfl assertion failed");

`endif

// File: hw/rtl/fbfl_pkg.sv
`default_nettype none

package fbfl_pkg;

	// Pool depth; the link memory and the clearing pass follow from it.
	localparam int POOL_BLOCKS = 1024;
	localparam int ADDR_W = $clog2(POOL_BLOCKS);

	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int OP_W = 1;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	localparam logic [APB_AW-1:0] REG_BLOCK_COUNT = 3'd0;
	localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ALLOC    = 2'd0,
		ST_FREED    = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BAD_FREE = 2'd3
	} status_t;

	typedef struct packed {
		op_t              opcode;
		logic [IDX_W-1:0] block_index;
	} req_word_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] granted_index;
		logic [CNT_W-1:0] free_count;
		logic [CNT_W-1:0] used_count;
	} rsp_word_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic take;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} ctrl_sts_t;

	// Effective pool size: a count above the pool depth acts as the depth.
	function automatic logic [CNT_W-1:0] pool_clamp(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] res;
		if (32'(cnt) > POOL_BLOCKS) begin
			res = CNT_W'(POOL_BLOCKS);
		end else begin
			res = cnt;
		end
		return res;
	endfunction

	// Block index to link memory address.
	function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
		logic [ADDR_W+IDX_W-1:0] w;
		w = '0;
		w[IDX_W-1:0] = idx;
		return w[ADDR_W-1:0];
	endfunction

	// Link value of a rebuilt entry, kept in index width.
	function automatic logic [IDX_W-1:0] seq_link(input logic [ADDR_W-1:0] addr);
		logic [ADDR_W+IDX_W:0] w;
		w = '0;
		w[ADDR_W:0] = {1'b0, addr} + (ADDR_W+1)'(1);
		return w[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fixed_block_free_list_allocator.sv
// Channel | Direction | Word                              | Handshake
// req     | in        | opcode, block_index               | req_valid / req_stall
// rsp     | out       | status, granted_index, counts     | rsp_valid / rsp_stall
// apb     | in/out    | block_count at byte address 0     | psel, penable, pready = 1
//
// Each request word is accepted in S_IDLE, where the link of the list head is
// read from the synchronous link memory, and committed in S_EXEC. After reset
// and after every write of block_count a clearing pass over all POOL_BLOCKS
// entries (1024) relinks the memory; req_stall is high during it.
// A finished result waits in the output register; the next word is accepted
// meanwhile and commits once that register is taken.
`default_nettype none

module fixed_block_free_list_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire fbfl_pkg::req_word_t           req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output fbfl_pkg::rsp_word_t                rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fbfl_pkg::APB_AW-1:0]   paddr,
	input  wire logic [fbfl_pkg::APB_DW-1:0]   pwdata,
	output logic [fbfl_pkg::APB_DW-1:0]        prdata,
	output logic                               pready
);

	fbfl_pkg::ctrl_cmd_t        cmd;
	fbfl_pkg::ctrl_sts_t        sts;
	logic                       cfg_wr;
	logic [fbfl_pkg::CNT_W-1:0] block_count;

	// Decode the single register; writes elsewhere are dropped.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == fbfl_pkg::REG_BLOCK_COUNT);
	assign prdata = (paddr == fbfl_pkg::REG_BLOCK_COUNT) ?
		fbfl_pkg::APB_DW'(block_count) : '0;

	// Sequencer: clearing pass, accept, commit.
	fbfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Link memory, list head, counts and output register.
	fbfl_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.cfg_data    (pwdata[fbfl_pkg::CNT_W-1:0]),
		.block_count (block_count),
		.req         (req),
		.rsp         (rsp),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

`include "fixed_block_free_list_allocator_assert.svh"

	// An accepted word keeps the input closed while it is worked on.
	`FBFL_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

	// A register write starts the clearing pass, which holds off requests.
	`FBFL_ASSERT_NEXT(a_clear_after_cfg, cfg_wr, req_stall)

	// Only a granted block carries an index.
	`FBFL_ASSERT_NOW(a_grant_zero,
		rsp_valid && rsp.status != fbfl_pkg::ST_ALLOC, rsp.granted_index == '0)

	// An empty answer means the free list really was empty.
	`FBFL_ASSERT_NOW(a_empty_count,
		rsp_valid && rsp.status == fbfl_pkg::ST_EMPTY, rsp.free_count == '0)

endmodule

`default_nettype wire

// File: hw/rtl/fbfl_ctrl.sv
`default_nettype none

module fbfl_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire fbfl_pkg::ctrl_sts_t sts,
	output fbfl_pkg::ctrl_cmd_t      cmd
);

	fbfl_pkg::state_t state_q;
	fbfl_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbfl_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fbfl_pkg::S_CLEAR: begin
				if (sts.clear_last) state_nxt = fbfl_pkg::S_IDLE;
			end
			fbfl_pkg::S_IDLE: begin
				if (req_valid) state_nxt = fbfl_pkg::S_EXEC;
			end
			fbfl_pkg::S_EXEC: begin
				if (sts.out_free) state_nxt = fbfl_pkg::S_IDLE;
			end
			default: state_nxt = fbfl_pkg::S_CLEAR;
		endcase
		// a register write restarts the rebuild
		if (cfg_wr) state_nxt = fbfl_pkg::S_CLEAR;
	end

	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		case (state_q)
			fbfl_pkg::S_CLEAR: begin
				cmd.clear_step = !cfg_wr;
			end
			fbfl_pkg::S_IDLE: begin
				req_stall = 1'b0;
				cmd.take = req_valid;
			end
			fbfl_pkg::S_EXEC: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/fbfl_dpath.sv
`default_nettype none

module fbfl_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr,
	input  wire logic [fbfl_pkg::CNT_W-1:0]   cfg_data,
	output logic [fbfl_pkg::CNT_W-1:0]        block_count,
	input  wire fbfl_pkg::req_word_t          req,
	output fbfl_pkg::rsp_word_t               rsp,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	input  wire fbfl_pkg::ctrl_cmd_t          cmd,
	output fbfl_pkg::ctrl_sts_t               sts
);

	logic [fbfl_pkg::IDX_W-1:0] link_mem [fbfl_pkg::POOL_BLOCKS];

	logic [fbfl_pkg::CNT_W-1:0]  block_count_q;
	logic [fbfl_pkg::CNT_W-1:0]  pool_size_q;
	logic [fbfl_pkg::IDX_W-1:0]  head_q;
	logic [fbfl_pkg::CNT_W-1:0]  free_q;
	logic [fbfl_pkg::CNT_W-1:0]  used_q;
	logic [fbfl_pkg::ADDR_W-1:0] clr_q;
	fbfl_pkg::op_t               op_q;
	logic [fbfl_pkg::IDX_W-1:0]  idx_q;
	logic [fbfl_pkg::IDX_W-1:0]  link_q;
	logic                        head_ok_q;
	fbfl_pkg::rsp_word_t         rsp_q;
	logic                        rsp_valid_q;

	fbfl_pkg::rsp_word_t         res;
	logic [fbfl_pkg::IDX_W-1:0]  head_nxt;
	logic                        push;

	// Outcome of the held item against the current list state.
	always_comb begin
		res = '0;
		res.free_count = free_q;
		res.used_count = used_q;
		head_nxt = head_q;
		push = 1'b0;
		case (op_q)
			fbfl_pkg::OP_ALLOC: begin
				if (free_q == '0) begin
					res.status = fbfl_pkg::ST_EMPTY;
				end else begin
					res.status = fbfl_pkg::ST_ALLOC;
					res.granted_index = head_q;
					res.free_count = free_q - fbfl_pkg::CNT_W'(1);
					res.used_count = used_q + fbfl_pkg::CNT_W'(1);
					head_nxt = head_ok_q ? link_q : '0;
				end
			end
			fbfl_pkg::OP_FREE: begin
				if ({1'b0, idx_q} >= pool_size_q || used_q == '0) begin
					res.status = fbfl_pkg::ST_BAD_FREE;
				end else begin
					res.status = fbfl_pkg::ST_FREED;
					res.free_count = free_q + fbfl_pkg::CNT_W'(1);
					res.used_count = used_q - fbfl_pkg::CNT_W'(1);
					head_nxt = idx_q;
					push = 1'b1;
				end
			end
			default: begin
				res.status = fbfl_pkg::ST_BAD_FREE;
			end
		endcase
	end

	// Link memory: one write port shared by the clearing pass and pushes.
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			link_mem[clr_q] <= fbfl_pkg::seq_link(clr_q);
		end else if (cmd.commit && push) begin
			link_mem[fbfl_pkg::to_addr(idx_q)] <= head_q;
		end
		if (cmd.take) begin
			link_q <= link_mem[fbfl_pkg::to_addr(head_q)];
			head_ok_q <= 32'(head_q) < fbfl_pkg::POOL_BLOCKS;
			op_q <= req.opcode;
			idx_q <= req.block_index;
		end
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= fbfl_pkg::BLOCK_COUNT_RESET;
			pool_size_q <= fbfl_pkg::pool_clamp(fbfl_pkg::BLOCK_COUNT_RESET);
			head_q <= '0;
			free_q <= fbfl_pkg::pool_clamp(fbfl_pkg::BLOCK_COUNT_RESET);
			used_q <= '0;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				block_count_q <= cfg_data;
				pool_size_q <= fbfl_pkg::pool_clamp(cfg_data);
				head_q <= '0;
				free_q <= fbfl_pkg::pool_clamp(cfg_data);
				used_q <= '0;
				clr_q <= '0;
			end else begin
				if (cmd.clear_step) clr_q <= clr_q + fbfl_pkg::ADDR_W'(1);
				if (cmd.commit) begin
					head_q <= head_nxt;
					free_q <= res.free_count;
					used_q <= res.used_count;
				end
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clear_last = clr_q == fbfl_pkg::ADDR_W'(fbfl_pkg::POOL_BLOCKS - 1);
	assign sts.out_free = !rsp_valid_q || !rsp_stall;
	assign block_count = block_count_q;
	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fbfl_pkg::*;

	// Receiver behaviors on the response channel.
	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN,
		STALL_HEAVY
	} stall_style_t;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 20000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_PRINTED = 40;

	// Drive every input to a known level from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_word_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_word_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	// Shadow copy of the pool: link memory, head, counts and the register.
	logic [IDX_W-1:0] link_mem [POOL_BLOCKS];
	logic [IDX_W-1:0] list_top;
	logic [CNT_W-1:0] free_left;
	logic [CNT_W-1:0] used_now;
	logic [CNT_W-1:0] bc_reg;

	// Response words owed by the block, oldest first.
	rsp_word_t pool_answers[$];
	// Blocks the stimulus believes are handed out; steers well-formed frees.
	int held_blocks[$];

	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	bit gaps_on = 1'b0;
	stall_style_t stall_style = STALL_NONE;
	int hold_request = 0;
	int hold_left = 0;
	int stall_phase = 0;

	fixed_block_free_list_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #2 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** fixed_block_free_list_allocator: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("mismatch %0s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
		end
	endtask

	// Blocks actually usable: a count above the pool depth acts as the depth.
	function automatic logic [CNT_W-1:0] usable_blocks();
		logic [CNT_W-1:0] n;
		n = bc_reg;
		if (int'(n) > POOL_BLOCKS) begin
			n = CNT_W'(POOL_BLOCKS);
		end
		return n;
	endfunction

	// Relink every entry in ascending order, block 0 at the head, none in use.
	task automatic relink_pool();
		for (int i = 0; i < POOL_BLOCKS; i++) begin
			link_mem[i] = IDX_W'(i + 1);
		end
		list_top = '0;
		free_left = usable_blocks();
		used_now = '0;
	endtask

	// Advance the shadow pool by one request word and return its answer.
	function automatic rsp_word_t apply_pool_op(input req_word_t w);
		rsp_word_t r;
		r = '0;
		if (w.opcode == OP_ALLOC) begin
			if (free_left == '0) begin
				r.status = ST_EMPTY;
			end else begin
				// pop the head; its link becomes the new head
				r.status = ST_ALLOC;
				r.granted_index = list_top;
				list_top = link_mem[list_top];
				free_left = free_left - CNT_W'(1);
				used_now = used_now + CNT_W'(1);
			end
		end else begin
			if ({1'b0, w.block_index} >= usable_blocks() || used_now == '0) begin
				// out-of-range index, or nothing in use: leave the pool alone
				r.status = ST_BAD_FREE;
			end else begin
				// push the block back as the new head; double frees are not caught
				r.status = ST_FREED;
				link_mem[w.block_index] = list_top;
				list_top = w.block_index;
				free_left = free_left + CNT_W'(1);
				used_now = used_now - CNT_W'(1);
			end
		end
		r.free_count = free_left;
		r.used_count = used_now;
		return r;
	endfunction

	// Receiver: a long hold-off when asked for, otherwise the current style.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_style)
				STALL_NONE: begin
					rsp_stall <= 1'b0;
				end
				STALL_RANDOM: begin
					rsp_stall <= ($urandom_range(0, 99) < 30);
				end
				STALL_PATTERN: begin
					// stall while the phase, stepping through 0 to 6, is below 3
					stall_phase = (stall_phase + 1) % 7;
					rsp_stall <= (stall_phase < 3);
				end
				default: begin
					rsp_stall <= ($urandom_range(0, 99) < 70);
				end
			endcase
		end
	end

	// Compare every accepted response word with the oldest owed answer.
	always @(posedge clk) begin : check_rsp
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pool_answers.size() == 0) begin
				report_mismatch("unexpected response word", 1, 0);
			end else begin
				want = pool_answers.pop_front();
				if (rsp.status !== want.status) begin
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				end
				if (rsp.granted_index !== want.granted_index) begin
					report_mismatch("granted_index", 32'(rsp.granted_index),
						32'(want.granted_index));
				end
				if (rsp.free_count !== want.free_count) begin
					report_mismatch("free_count", 32'(rsp.free_count), 32'(want.free_count));
				end
				if (rsp.used_count !== want.used_count) begin
					report_mismatch("used_count", 32'(rsp.used_count), 32'(want.used_count));
				end
			end
		end
	end

	// Offer one request word, in bursts with random gaps when enabled, and
	// record its answer at the edge that accepts it.
	task automatic send_word(input req_word_t w);
		rsp_word_t r;
		int hit[$];
		if (gaps_on && burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		r = apply_pool_op(w);
		pool_answers.push_back(r);
		// keep the list of handed-out blocks in step with the pool
		if (r.status == ST_ALLOC) begin
			held_blocks.push_back(int'(r.granted_index));
		end else if (r.status == ST_FREED) begin
			hit = held_blocks.find_first_index(x) with (x == int'(w.block_index));
			if (hit.size() != 0) begin
				held_blocks.delete(hit[0]);
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	task automatic send_op(input op_t op, input int idx);
		req_word_t w;
		w.opcode = op;
		w.block_index = IDX_W'(idx);
		send_word(w);
	endtask

	// Drop valid, wait for every owed word, then let the pipeline settle.
	task automatic wait_drained();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		while (pool_answers.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pool_answers.size() != 0) begin
			report_mismatch("words never returned", 0, pool_answers.size());
			pool_answers.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write block_count over the configuration port once the block is idle,
	// then read it back. The write relinks the pool.
	task automatic write_block_count(input logic [CNT_W-1:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_BLOCK_COUNT;
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands at this edge; go straight into a read setup
		penable <= 1'b0;
		pwrite <= 1'b0;
		bc_reg = value;
		relink_pool();
		held_blocks.delete();
		burst_left = 0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CNT_W-1:0] !== value) begin
			report_mismatch("block_count readback", 32'(prdata[CNT_W-1:0]), 32'(value));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Pool straight out of reset: ascending pops, push back, double free of
	// a block never handed out, index extremes.
	task automatic test_reset_pool();
		gaps_on = 1'b1;
		stall_style = STALL_RANDOM;
		send_op(OP_ALLOC, 1023);
		send_op(OP_ALLOC, 0);
		send_op(OP_ALLOC, 0);
		send_op(OP_FREE, 1);
		send_op(OP_ALLOC, 0);
		send_op(OP_FREE, 1023);
		send_op(OP_ALLOC, 0);
		send_op(OP_FREE, 0);
	endtask

	// One block: empty pool, bad index, free with nothing in use.
	task automatic test_single_block();
		write_block_count(CNT_W'(1));
		send_op(OP_ALLOC, 0);
		send_op(OP_ALLOC, 0);
		send_op(OP_FREE, 1);
		send_op(OP_FREE, 0);
		send_op(OP_FREE, 0);
	endtask

	// No blocks at all.
	task automatic test_zero_pool();
		write_block_count(CNT_W'(0));
		send_op(OP_ALLOC, 0);
		send_op(OP_FREE, 0);
	endtask

	// Two blocks: drain to the last link, double free hands one block out twice.
	task automatic test_double_free();
		write_block_count(CNT_W'(2));
		stall_style = STALL_PATTERN;
		send_op(OP_ALLOC, 0);
		send_op(OP_ALLOC, 0);
		send_op(OP_FREE, 0);
		send_op(OP_FREE, 0);
		send_op(OP_ALLOC, 0);
		send_op(OP_ALLOC, 0);
		send_op(OP_ALLOC, 0);
	endtask

	// All register bits high: acts as the full pool, reads back as written.
	task automatic test_oversized_count();
		write_block_count(CNT_W'(2047));
		send_op(OP_ALLOC, 0);
		send_op(OP_FREE, 1023);
		send_op(OP_ALLOC, 0);
	endtask

	// Hold the receiver off for a long stretch while the sender keeps
	// offering words back to back, so the block fills and stalls its input.
	task automatic test_output_backpressure();
		write_block_count(CNT_W'(200));
		gaps_on = 1'b0;
		stall_style = STALL_NONE;
		// wait out the clearing pass so the hold-off meets live traffic
		while (req_stall) @(posedge clk);
		hold_request = HOLD_OFF_CYCLES;
		for (int n = 0; n < 40; n++) begin
			if (n % 4 == 3 && held_blocks.size() != 0) begin
				send_op(OP_FREE, held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
			end else begin
				send_op(OP_ALLOC, $urandom_range(0, 1023));
			end
		end
	endtask

	// One phase of random traffic: mostly allocates and frees of blocks in
	// hand, plus stray indexes, double frees and out-of-range frees.
	task automatic run_random_phase(input logic [CNT_W-1:0] count_value, input int words,
			input int alloc_pct, input bit gaps, input stall_style_t style);
		int pick;
		int noise;
		int sz;
		write_block_count(count_value);
		gaps_on = gaps;
		stall_style = style;
		for (int n = 0; n < words; n++) begin
			pick = $urandom_range(0, 99);
			noise = $urandom_range(0, 99);
			sz = int'(usable_blocks());
			if (pick < alloc_pct || (held_blocks.size() == 0 && noise < 80)) begin
				send_op(OP_ALLOC, $urandom_range(0, 1023));
			end else if (noise < 85 && held_blocks.size() != 0) begin
				send_op(OP_FREE, held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
			end else if (noise < 93) begin
				send_op(OP_FREE, $urandom_range(0, 1023));
			end else if (sz < POOL_BLOCKS) begin
				send_op(OP_FREE, $urandom_range(sz, POOL_BLOCKS - 1));
			end else begin
				send_op(OP_FREE, POOL_BLOCKS - 1);
			end
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(CNT_W'(1024), 150, 60, 1'b1, STALL_RANDOM);
		run_random_phase(CNT_W'(3), 100, 50, 1'b1, STALL_PATTERN);
		run_random_phase(CNT_W'(64), 150, 55, 1'b1, STALL_HEAVY);
		run_random_phase(CNT_W'(2047), 120, 75, 1'b0, STALL_NONE);
		run_random_phase(CNT_W'(1), 60, 50, 1'b1, STALL_RANDOM);
		run_random_phase(CNT_W'(1025), 100, 55, 1'b0, STALL_PATTERN);
		run_random_phase(CNT_W'(16), 100, 55, 1'b1, STALL_RANDOM);
		run_random_phase(CNT_W'($urandom_range(2, 40)), 80, 55, 1'b1, STALL_HEAVY);
		run_random_phase(CNT_W'(0), 20, 50, 1'b0, STALL_NONE);
	endtask

	initial begin
		bc_reg = BLOCK_COUNT_RESET;
		relink_pool();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// words offered now wait out the clearing pass behind req_stall
		test_reset_pool();
		test_single_block();
		test_zero_pool();
		test_double_free();
		test_oversized_count();
		test_output_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (16) @(posedge clk);
		if (errors == 0) begin
			$display("** fixed_block_free_list_allocator: PASSED **");
		end else begin
			$display("** fixed_block_free_list_allocator: FAILED **");
		end
		$finish;
	end

endmodule
